// ----- hw/rtl/cdsb_pkg.sv -----
// Package with shared types, constants and weight functions of the chroma downsampler.
`timescale 1ns / 1ps
package cdsb_pkg;
  localparam int MAX_BLOCK = 4;
  localparam int MAX_LINE = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int SITE_FRAC_BITS = 4;
  localparam int SITE_ONE = 1 << SITE_FRAC_BITS;
  localparam int LINE_AW = $clog2(MAX_LINE);
  localparam int ACC_W = 26;
  localparam int WSUM_W = 7;
  localparam int PROD_W = 2 * WSUM_W;

  // Register indexes.
  localparam logic [2:0] REG_IMG_W = 3'd0;
  localparam logic [2:0] REG_IMG_H = 3'd1;
  localparam logic [2:0] REG_BLK_W = 3'd2;
  localparam logic [2:0] REG_BLK_H = 3'd3;
  localparam logic [2:0] REG_U_SX = 3'd4;
  localparam logic [2:0] REG_U_SY = 3'd5;
  localparam logic [2:0] REG_V_SX = 3'd6;
  localparam logic [2:0] REG_V_SY = 3'd7;

  // Classified pixel handed from the front to the back.
  typedef struct packed {
    logic [15:0]       u;
    logic [15:0]       v;
    logic [PROD_W-1:0] wu;
    logic [PROD_W-1:0] wv;
    logic [11:0]       bc;
    logic [15:0]       br;
    logic              first;
    logic              emit;
    logic              flast;
  } work_t;

  // Hat weight of block position b for a sample point at site.
  function automatic logic [4:0] hat(input logic [5:0] site, input logic [2:0] b);
    logic signed [8:0] d;
    d = $signed({3'b0, site}) - $signed({2'b0, b, 4'b0});
    if (d < 0) d = -d;
    if (d >= 9'sd16) return 5'd0;
    return 5'(9'sd16 - d);
  endfunction

  // Sum of weights for positions first..last of a block.
  function automatic logic [WSUM_W-1:0] span(input logic [5:0] site,
                                             input logic [2:0] first,
                                             input logic [2:0] last);
    logic [WSUM_W-1:0] s;
    s = '0;
    for (int b = 0; b < MAX_BLOCK; b++) begin
      if (3'(b) >= first && 3'(b) <= last) s = s + WSUM_W'(hat(site, 3'(b)));
    end
    return s;
  endfunction
endpackage

// ----- hw/rtl/chroma_downsampler_bilinear.sv -----
// Top level of the bilinear chroma downsampler.
// The block takes full-resolution U/V pixels in raster order on the in_ stream
// (tdata: u_in in bits 15:0, v_in in bits 31:16) and returns one subsampled
// U/V pair per macro block on the out_ stream (tdata: u_out, v_out; tuser:
// out_col, out_row; tlast: frame_last). Results appear in block order as the
// last pixel of each block arrives.
// Each pixel passes a front stage that tracks the raster position and forms its
// bilinear weight, a two-entry queue, and a back end that does a read, add and
// write back on the per-column accumulator memory. The back end takes no new
// pixel until the last is written back, and out_tvalid rises with the write
// back of a block's last pixel. Configuration is written by the user through
// the cfg_ APB port only while the block is idle, which the block does not
// enforce; any write restarts the frame at pixel zero. A stalled receiver
// fills the result register, the queue and the front register, after which
// in_tready drops. Reset (rst_n, synchronous) loads the register defaults,
// clears the raster position and empties the pipeline. Accumulators need no
// clearing, since the first pixel of each block overwrites its column entry.
`timescale 1ns / 1ps
module chroma_downsampler_bilinear (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // u_in[15:0], v_in[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // u_out[15:0], v_out[31:16]
  output logic [27:0] out_tuser,  // out_col[11:0], out_row[27:12]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [12:0] img_w_r;
  logic [15:0] img_h_r;
  logic [2:0]  blk_w_r, blk_h_r;
  logic [5:0]  usx_r, usy_r, vsx_r, vsy_r;
  logic        wr;
  logic [2:0]  ri;
  logic        qv, qr, fv, fr;
  cdsb_pkg::work_t qd, fd;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ri = cfg_paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 13'd1920; img_h_r <= 16'd1080; blk_w_r <= 3'd2; blk_h_r <= 3'd2;
      usx_r <= '0; usy_r <= '0; vsx_r <= '0; vsy_r <= '0;
    end else if (wr) begin
      unique case (ri)
        cdsb_pkg::REG_IMG_W: img_w_r <= cfg_pwdata[12:0];
        cdsb_pkg::REG_IMG_H: img_h_r <= cfg_pwdata[15:0];
        cdsb_pkg::REG_BLK_W: blk_w_r <= cfg_pwdata[2:0];
        cdsb_pkg::REG_BLK_H: blk_h_r <= cfg_pwdata[2:0];
        cdsb_pkg::REG_U_SX:  usx_r <= cfg_pwdata[5:0];
        cdsb_pkg::REG_U_SY:  usy_r <= cfg_pwdata[5:0];
        cdsb_pkg::REG_V_SX:  vsx_r <= cfg_pwdata[5:0];
        cdsb_pkg::REG_V_SY:  vsy_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (ri)
      cdsb_pkg::REG_IMG_W: cfg_prdata = {19'd0, img_w_r};
      cdsb_pkg::REG_IMG_H: cfg_prdata = {16'd0, img_h_r};
      cdsb_pkg::REG_BLK_W: cfg_prdata = {29'd0, blk_w_r};
      cdsb_pkg::REG_BLK_H: cfg_prdata = {29'd0, blk_h_r};
      cdsb_pkg::REG_U_SX:  cfg_prdata = {26'd0, usx_r};
      cdsb_pkg::REG_U_SY:  cfg_prdata = {26'd0, usy_r};
      cdsb_pkg::REG_V_SX:  cfg_prdata = {26'd0, vsx_r};
      cdsb_pkg::REG_V_SY:  cfg_prdata = {26'd0, vsy_r};
      default: cfg_prdata = '0;
    endcase
  end

  cdsb_front u_front (
    .clk, .rst_n, .restart(wr),
    .image_width(img_w_r), .image_height(img_h_r),
    .block_width(blk_w_r), .block_height(blk_h_r),
    .u_site_x(usx_r), .u_site_y(usy_r), .v_site_x(vsx_r), .v_site_y(vsy_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .u_in(in_tdata[15:0]), .v_in(in_tdata[31:16]),
    .q_valid(qv), .q_ready(qr), .q_data(qd)
  );

  cdsb_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(qv), .wr_ready(qr), .wr_data(qd),
    .rd_valid(fv), .rd_ready(fr), .rd_data(fd)
  );

  cdsb_back u_back (
    .clk, .rst_n,
    .q_valid(fv), .q_ready(fr), .q_data(fd),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );
endmodule

// ----- hw/rtl/cdsb_front.sv -----
// Front end: raster position tracking and weight classification of each pixel.
`timescale 1ns / 1ps
module cdsb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic [12:0]        image_width,
  input  logic [15:0]        image_height,
  input  logic [2:0]         block_width,
  input  logic [2:0]         block_height,
  input  logic [5:0]         u_site_x,
  input  logic [5:0]         u_site_y,
  input  logic [5:0]         v_site_x,
  input  logic [5:0]         v_site_y,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        u_in,
  input  logic [15:0]        v_in,
  output logic               q_valid,
  input  logic               q_ready,
  output cdsb_pkg::work_t    q_data
);
  logic [11:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [2:0]  bx_r, bx_nxt, by_r, by_nxt;
  logic [11:0] bc_r, bc_nxt;
  logic [15:0] br_r, br_nxt;
  logic        q_valid_r;
  cdsb_pkg::work_t q_data_r;

  logic [12:0] w;
  logic [15:0] h;
  logic [2:0]  bw, bh;
  logic        last_col, last_row;
  logic [2:0]  bx_end, by_end;
  logic [cdsb_pkg::WSUM_W-1:0] sux, suy, svx, svy;
  logic        fire;

  // Clamp the geometry registers.
  always_comb begin
    w = (image_width == 13'd0) ? 13'd1 :
        (image_width > 13'(cdsb_pkg::MAX_LINE)) ? 13'(cdsb_pkg::MAX_LINE) : image_width;
    h = (image_height == 16'd0) ? 16'd1 : image_height;
    bw = (block_width == 3'd0) ? 3'd1 :
         (block_width > 3'(cdsb_pkg::MAX_BLOCK)) ? 3'(cdsb_pkg::MAX_BLOCK) : block_width;
    bh = (block_height == 3'd0) ? 3'd1 :
         (block_height > 3'(cdsb_pkg::MAX_BLOCK)) ? 3'(cdsb_pkg::MAX_BLOCK) : block_height;
  end

  // Classify the current position.
  always_comb begin
    last_col = ({1'b0, col_r} == w - 13'd1);
    last_row = (row_r == h - 16'd1);
    bx_end = last_col ? bw - 3'd1 : bx_r;
    by_end = last_row ? bh - 3'd1 : by_r;
    sux = cdsb_pkg::span(u_site_x, bx_r, bx_end);
    suy = cdsb_pkg::span(u_site_y, by_r, by_end);
    svx = cdsb_pkg::span(v_site_x, bx_r, bx_end);
    svy = cdsb_pkg::span(v_site_y, by_r, by_end);
  end

  assign in_ready = !q_valid_r || q_ready;
  assign fire = in_valid && in_ready;

  // Advance the raster and block counters.
  always_comb begin
    col_nxt = col_r; row_nxt = row_r; bx_nxt = bx_r; by_nxt = by_r;
    bc_nxt = bc_r; br_nxt = br_r;
    if (fire) begin
      if (last_col) begin
        col_nxt = '0; bx_nxt = '0; bc_nxt = '0;
        if (last_row) begin
          row_nxt = '0; by_nxt = '0; br_nxt = '0;
        end else begin
          row_nxt = row_r + 16'd1;
          if (by_r == bh - 3'd1) begin
            by_nxt = '0; br_nxt = br_r + 16'd1;
          end else begin
            by_nxt = by_r + 3'd1;
          end
        end
      end else begin
        col_nxt = col_r + 12'd1;
        if (bx_r == bw - 3'd1) begin
          bx_nxt = '0; bc_nxt = bc_r + 12'd1;
        end else begin
          bx_nxt = bx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0; row_r <= '0; bx_r <= '0; by_r <= '0; bc_r <= '0; br_r <= '0;
    end else begin
      col_r <= col_nxt; row_r <= row_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
      bc_r <= bc_nxt; br_r <= br_nxt;
    end
  end

  // Output register toward the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_ready) begin
      q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      q_data_r.u <= u_in;
      q_data_r.v <= v_in;
      q_data_r.wu <= cdsb_pkg::PROD_W'(sux) * cdsb_pkg::PROD_W'(suy);
      q_data_r.wv <= cdsb_pkg::PROD_W'(svx) * cdsb_pkg::PROD_W'(svy);
      q_data_r.bc <= bc_r;
      q_data_r.br <= br_r;
      q_data_r.first <= (bx_r == 3'd0) && (by_r == 3'd0);
      q_data_r.emit <= (bx_r == bw - 3'd1 || last_col) && (by_r == bh - 3'd1 || last_row);
      q_data_r.flast <= last_col && last_row;
    end
  end

  assign q_valid = q_valid_r;
  assign q_data = q_data_r;

  // The pixel column stays below the maximum line length.
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < 13'(cdsb_pkg::MAX_LINE)) else $error("column out of range");
  a_bx_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    bx_r < 3'(cdsb_pkg::MAX_BLOCK)) else $error("bx out of block");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_ready |=> q_valid) else $error("queue item dropped");
endmodule

// ----- hw/rtl/cdsb_fifo.sv -----
// Short queue between the front and the back end.
`timescale 1ns / 1ps
module cdsb_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  cdsb_pkg::work_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output cdsb_pkg::work_t rd_data
);
  cdsb_pkg::work_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !rd_ready |=> cnt_r == 2'd2) else $error("queue count lost");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 && !wr_valid |=> cnt_r == 2'd0) else $error("queue invented item");
endmodule

// ----- hw/rtl/cdsb_back.sv -----
// Back end: line accumulator memories, weighting, rounding and result register.
`timescale 1ns / 1ps
module cdsb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  cdsb_pkg::work_t q_data,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic [27:0]     out_tuser,
  output logic            out_tlast
);
  localparam int AW = cdsb_pkg::LINE_AW;
  localparam int AC = cdsb_pkg::ACC_W;

  // Phases: fetch the partial sums, then add and write back.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_ADD  = 3'b100
  } st_t;

  st_t st_r, st_nxt;
  logic [AC-1:0] u_mem [cdsb_pkg::MAX_LINE];
  logic [AC-1:0] v_mem [cdsb_pkg::MAX_LINE];
  logic [AC-1:0] u_rd_r, v_rd_r;
  cdsb_pkg::work_t w_r;
  logic [AC-1:0] cu_r, cv_r;
  logic [AC-1:0] su, sv;
  logic          ov_r;
  logic [31:0]   data_r;
  logic [27:0]   user_r;
  logic          last_r;
  logic          take, wb;

  assign ov_r = out_tvalid;
  assign q_ready = (st_r == ST_IDLE) && (!ov_r || out_tready);
  assign take = q_valid && q_ready;
  assign wb = (st_r == ST_ADD);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (take) st_nxt = ST_READ;
      ST_READ: st_nxt = ST_ADD;
      ST_ADD:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  // Capture the item and form the weighted contributions.
  always_ff @(posedge clk) begin
    if (take) begin
      w_r <= q_data;
      cu_r <= AC'(q_data.wu) * AC'(q_data.u);
      cv_r <= AC'(q_data.wv) * AC'(q_data.v);
    end
  end

  // Line accumulator memories.
  always_ff @(posedge clk) begin
    if (st_r == ST_READ) begin
      u_rd_r <= u_mem[w_r.bc[AW-1:0]];
      v_rd_r <= v_mem[w_r.bc[AW-1:0]];
    end
    if (wb) begin
      u_mem[w_r.bc[AW-1:0]] <= su;
      v_mem[w_r.bc[AW-1:0]] <= sv;
    end
  end

  assign su = w_r.first ? cu_r : u_rd_r + cu_r;
  assign sv = w_r.first ? cv_r : v_rd_r + cv_r;

  function automatic logic [15:0] fin(input logic [AC-1:0] a);
    logic [AC:0] r;
    r = ({1'b0, a} + (AC+1)'(1 << (2 * cdsb_pkg::SITE_FRAC_BITS - 1)))
        >> (2 * cdsb_pkg::SITE_FRAC_BITS);
    if (r > (AC+1)'(16'hFFFF)) return 16'hFFFF;
    return r[15:0];
  endfunction

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (wb && w_r.emit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb && w_r.emit) begin
      data_r <= {fin(sv), fin(su)};
      user_r <= {w_r.br, w_r.bc};
      last_r <= w_r.flast;
    end
  end

  assign out_tdata = data_r;
  assign out_tuser = user_r;
  assign out_tlast = last_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_READ |=> st_r == ST_ADD) else $error("missed add phase");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(wb && w_r.emit)) else $error("result overwritten");
endmodule

// ----- dv/cdsb_checker.sv -----
// Checker for the chroma downsampler: predicts subsampled U/V samples and compares the results.
`timescale 1ns / 1ps
module cdsb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [27:0] out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          samples_checked
);

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
    logic [11:0] col;
    logic [15:0] row;
    logic        flast;
  } chroma_sample_t;

  chroma_sample_t sample_q[$];

  // Shadow copy of the register file and the raster state.
  int unsigned img_w, img_h, blk_w, blk_h, usx, usy, vsx, vsy;
  int unsigned pix_col, pix_row;
  longint unsigned u_sum[cdsb_pkg::MAX_LINE];
  longint unsigned v_sum[cdsb_pkg::MAX_LINE];

  function automatic int unsigned tap_weight(int unsigned site, int unsigned pos);
    int d;
    d = int'(site) - int'(pos * cdsb_pkg::SITE_ONE);
    if (d < 0) d = -d;
    return (d >= cdsb_pkg::SITE_ONE) ? 0 : cdsb_pkg::SITE_ONE - d;
  endfunction

  // Positions past the image edge fold onto the edge pixel, so their weights add up.
  function automatic int unsigned weight_sum(int unsigned site, int unsigned first,
                                             int unsigned last);
    int unsigned s;
    s = 0;
    for (int unsigned b = first; b <= last; b++) s += tap_weight(site, b);
    return s;
  endfunction

  function automatic logic [15:0] round_sat(longint unsigned acc);
    longint unsigned r;
    r = (acc + 128) >> 8;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  // Accumulate one pixel; queue a sample when it completes a macro block.
  task automatic downsample_pixel(logic [15:0] u, logic [15:0] v);
    int unsigned w, h, bw, bh, col, row, bc, bx, br, by, bx_end, by_end, idx;
    longint unsigned cu, cv;
    bit last_col, last_row;
    chroma_sample_t s;
    w = (img_w < 1) ? 1 : (img_w > cdsb_pkg::MAX_LINE) ? cdsb_pkg::MAX_LINE : img_w;
    h = (img_h < 1) ? 1 : img_h;
    bw = (blk_w < 1) ? 1 : (blk_w > cdsb_pkg::MAX_BLOCK) ? cdsb_pkg::MAX_BLOCK : blk_w;
    bh = (blk_h < 1) ? 1 : (blk_h > cdsb_pkg::MAX_BLOCK) ? cdsb_pkg::MAX_BLOCK : blk_h;
    col = (pix_col < w) ? pix_col : w - 1;
    row = (pix_row < h) ? pix_row : h - 1;
    bc = col / bw;
    bx = col % bw;
    br = row / bh;
    by = row % bh;
    last_col = (col == w - 1);
    last_row = (row == h - 1);
    bx_end = last_col ? bw - 1 : bx;
    by_end = last_row ? bh - 1 : by;
    idx = bc % cdsb_pkg::MAX_LINE;
    cu = longint'(weight_sum(usx, bx, bx_end)) * weight_sum(usy, by, by_end) * u;
    cv = longint'(weight_sum(vsx, bx, bx_end)) * weight_sum(vsy, by, by_end) * v;
    if (bx == 0 && by == 0) begin
      u_sum[idx] = cu;
      v_sum[idx] = cv;
    end else begin
      u_sum[idx] += cu;
      v_sum[idx] += cv;
    end
    if ((bx == bw - 1 || last_col) && (by == bh - 1 || last_row)) begin
      s.u = round_sat(u_sum[idx]);
      s.v = round_sat(v_sum[idx]);
      s.col = bc[11:0];
      s.row = br[15:0];
      s.flast = last_col && last_row;
      sample_q.push_back(s);
    end
    if (last_col) begin
      pix_col = 0;
      pix_row = last_row ? 0 : row + 1;
    end else begin
      pix_col = col + 1;
      pix_row = row;
    end
  endtask

  task automatic report(string what, int exp_v, int got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    logic [15:0] val;
    chroma_sample_t e;
    if (!rst_n) begin
      img_w = 1920; img_h = 1080; blk_w = 2; blk_h = 2;
      usx = 0; usy = 0; vsx = 0; vsy = 0;
      pix_col = 0; pix_row = 0;
      sample_q.delete();
    end else begin
      // Register writes restart the frame.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        val = cfg_pwdata[15:0];
        case (cfg_paddr[4:2])
          cdsb_pkg::REG_IMG_W: img_w = val & 16'h1FFF;
          cdsb_pkg::REG_IMG_H: img_h = val;
          cdsb_pkg::REG_BLK_W: blk_w = val & 16'h7;
          cdsb_pkg::REG_BLK_H: blk_h = val & 16'h7;
          cdsb_pkg::REG_U_SX:  usx = val & 16'h3F;
          cdsb_pkg::REG_U_SY:  usy = val & 16'h3F;
          cdsb_pkg::REG_V_SX:  vsx = val & 16'h3F;
          cdsb_pkg::REG_V_SY:  vsy = val & 16'h3F;
          default: ;
        endcase
        pix_col = 0;
        pix_row = 0;
      end
      if (in_tvalid && in_tready) downsample_pixel(in_tdata[15:0], in_tdata[31:16]);
      // Compare each delivered sample against the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (sample_q.size() == 0) begin
          report("unexpected sample", 0, 1);
        end else begin
          e = sample_q.pop_front();
          samples_checked++;
          if (out_tdata[15:0] !== e.u) report("u_out", e.u, out_tdata[15:0]);
          if (out_tdata[31:16] !== e.v) report("v_out", e.v, out_tdata[31:16]);
          if (out_tuser[11:0] !== e.col) report("out_col", e.col, out_tuser[11:0]);
          if (out_tuser[27:12] !== e.row) report("out_row", e.row, out_tuser[27:12]);
          if (out_tlast !== e.flast) report("frame_last", e.flast, out_tlast);
        end
      end
    end
    pending = sample_q.size();
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the chroma downsampler: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [27:0] out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count, pending, samples_checked;
  int cycles = 0;
  int pixels_sent = 0;
  int phases_run = 0;
  int burst_left = 0;

  chroma_downsampler_bilinear i_dut (.*);

  cdsb_checker i_checker (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall pattern; its mode follows bits 9:8 of the cycle counter.
  always @(posedge clk) begin
    case (cycles[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 1) == 1);
      2'd2: out_tready <= (cycles[1:0] != 2'd0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(logic [2:0] idx, int unsigned value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Drain every expected sample and let trailing no-result pixels leave the pipe.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_format(int unsigned w, int unsigned h, int unsigned bw, int unsigned bh,
                            int unsigned ux, int unsigned uy, int unsigned vx,
                            int unsigned vy);
    drain();
    write_reg(cdsb_pkg::REG_IMG_W, w);
    write_reg(cdsb_pkg::REG_IMG_H, h);
    write_reg(cdsb_pkg::REG_BLK_W, bw);
    write_reg(cdsb_pkg::REG_BLK_H, bh);
    write_reg(cdsb_pkg::REG_U_SX, ux);
    write_reg(cdsb_pkg::REG_U_SY, uy);
    write_reg(cdsb_pkg::REG_V_SX, vx);
    write_reg(cdsb_pkg::REG_V_SY, vy);
    phases_run++;
  endtask

  // Send one item, with the sender idling between bursts. Called in the time step of a
  // rising edge; returns in the time step of the edge that accepted the item.
  task automatic send_pixel(logic [15:0] u, logic [15:0] v);
    int gap;
    bit ready_seen;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {v, u};
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    pixels_sent++;
  endtask

  function automatic int unsigned pick_site();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(49, 63) : $urandom_range(0, 48);
  endfunction

  initial begin
    int unsigned w, h;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small frame, full-scale values, two different sample points.
    set_format(3, 2, 2, 2, 8, 8, 16, 16);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000);
    send_pixel(16'hAAAA, 16'h5555);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'hFFFF, 16'hFFFF);
    // One-pixel image: every pixel is a whole frame.
    set_format(1, 1, 1, 1, 0, 0, 0, 0);
    send_pixel(16'hFFFF, 16'h0001);
    send_pixel(16'h8000, 16'h7FFF);
    // Zero and oversized sizes are clamped; sample points at and past the last block position.
    set_format(5, 0, 7, 0, 63, 63, 48, 48);
    repeat (5) send_pixel(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    // Widest and tallest image register settings.
    set_format(8191, 65535, 4, 4, 24, 40, 48, 0);
    repeat (8) send_pixel(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    set_format(4096, 1, 1, 4, 0, 48, 16, 32);
    repeat (4) send_pixel(16'hFFFF, 16'hFFFF);

    // Random formats, mostly small images so that frames wrap.
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(0, 5))
        0: begin w = $urandom_range(4090, 8191); h = $urandom_range(1, 3); end
        1: begin w = $urandom_range(0, 16); h = $urandom_range(65530, 65535); end
        default: begin w = $urandom_range(0, 12); h = $urandom_range(0, 8); end
      endcase
      set_format(w, h, $urandom_range(0, 7), $urandom_range(0, 7), pick_site(), pick_site(),
                 pick_site(), pick_site());
      repeat (50) send_pixel(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end

    drain();
    $display("Covered %0d pixels over %0d register settings; %0d subsampled samples checked.",
             pixels_sent, phases_run, samples_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cdsb_pkg.sv
hw/rtl/cdsb_front.sv
hw/rtl/cdsb_fifo.sv
hw/rtl/cdsb_back.sv
hw/rtl/chroma_downsampler_bilinear.sv
dv/cdsb_checker.sv
dv/tb.sv
